[design/umec_pkg.sv]
// shared types, field widths, opcodes and request kinds of the execute core
package umec_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_W    = 32;
  localparam int KIND_W    = 4;
  localparam int OP_W      = 4;
  localparam int LV_W      = 25;
  localparam int CHAR_W    = 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_DONE     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_STORE    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MAP      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_UNMAP    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_OUTPUT   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LOADPROG = 4'd6;
  localparam logic [KIND_W-1:0] KIND_HALT     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FAULT    = 4'd8;

  // opcodes
  localparam logic [OP_W-1:0] OP_CMOV  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_STORE = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
  localparam logic [OP_W-1:0] OP_NAND  = 4'd6;
  localparam logic [OP_W-1:0] OP_HALT  = 4'd7;
  localparam logic [OP_W-1:0] OP_MAP   = 4'd8;
  localparam logic [OP_W-1:0] OP_UNMAP = 4'd9;
  localparam logic [OP_W-1:0] OP_OUT   = 4'd10;
  localparam logic [OP_W-1:0] OP_IN    = 4'd11;
  localparam logic [OP_W-1:0] OP_LDPRG = 4'd12;
  localparam logic [OP_W-1:0] OP_LDVAL = 4'd13;

  // action codes
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_RESP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] instruction;
    logic [CHAR_W-1:0] input_char;
    logic              input_end;
    logic [WORD_W-1:0] response_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] request_kind;
    logic [WORD_W-1:0] segment_id;
    logic [WORD_W-1:0] word_offset;
    logic [WORD_W-1:0] data_value;
    logic [WORD_W-1:0] next_pc;
  } out_item_t;

endpackage

[design/universal_machine_execute_core.sv]
// execute core top level: sequencer, decode, state registers and output register
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_item  (umec_pkg::in_item_t)
//  out      output     out_valid / out_ready  out_item (umec_pkg::out_item_t)
//
// an item steps through accept with read of B and C, read of A, execute, commit
// divide adds a wait state while the bit-serial divider runs
// the registered read ports of the register file memory set the two read steps
// rst is synchronous; registers read as zero until first written
// a result waits in the output register while the next item is taken;
// commit of the following item stalls until that register is free
module universal_machine_execute_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  umec_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output umec_pkg::out_item_t out_item
);
  import umec_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDA  = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  in_item_t          it;
  logic [WORD_W-1:0] pc;
  logic [REG_AW-1:0] pend_reg;
  logic              pend_valid;
  logic              halted;

  logic [WORD_W-1:0] rb;
  logic [WORD_W-1:0] rc;
  logic [WORD_W-1:0] ra;

  // register file ports
  logic [REG_AW-1:0] rd0_addr;
  logic [REG_AW-1:0] rd1_addr;
  logic [WORD_W-1:0] rd0_data;
  logic [WORD_W-1:0] rd1_data;
  logic              wr_en;

  // committed effects computed in execute
  out_item_t         res;
  logic              wb_en;
  logic [REG_AW-1:0] wb_addr;
  logic [WORD_W-1:0] wb_data;
  logic              pc_upd;
  logic [WORD_W-1:0] pc_new;
  logic              set_pend;
  logic              clr_pend;
  logic [REG_AW-1:0] pend_new;
  logic              set_halt;

  // execute decode results
  out_item_t         x_res;
  logic              x_wb_en;
  logic [REG_AW-1:0] x_wb_addr;
  logic [WORD_W-1:0] x_wb_data;
  logic              x_pc_upd;
  logic [WORD_W-1:0] x_npc;
  logic              x_set_pend;
  logic              x_clr_pend;
  logic [REG_AW-1:0] x_pend_new;
  logic              x_set_halt;
  logic              x_div;

  logic [OP_W-1:0]   op;
  logic [REG_AW-1:0] fa;
  logic [REG_AW-1:0] fb;
  logic [REG_AW-1:0] fc;
  logic              div_busy;
  logic [WORD_W-1:0] div_quo;
  logic              out_free;
  logic              commit;

  assign op = it.instruction[WORD_W-1 -: OP_W];
  assign fa = it.instruction[8:6];
  assign fb = it.instruction[5:3];
  assign fc = it.instruction[2:0];
  assign ra = rd0_data;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == ST_FIN) && out_free;

  // read addresses: B and C at accept, A in the cycle after
  always_comb begin
    if (state == ST_IDLE) begin
      rd0_addr = in_item.instruction[5:3];
      rd1_addr = in_item.instruction[2:0];
    end else begin
      rd0_addr = fa;
      rd1_addr = fc;
    end
  end

  assign wr_en = commit && wb_en;

  umec_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd0_addr (rd0_addr),
    .rd1_addr (rd1_addr),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data),
    .wr_en    (wr_en),
    .wr_addr  (wb_addr),
    .wr_data  (wb_data)
  );

  umec_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == ST_EXEC) && x_div),
    .dividend (rb),
    .divisor  (rc),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // instruction decode and execute
  always_comb begin
    x_res        = '0;
    x_wb_en      = 1'b0;
    x_wb_addr    = fa;
    x_wb_data    = '0;
    x_npc        = pc + WORD_W'(1);
    x_pc_upd     = 1'b0;
    x_set_pend   = 1'b0;
    x_clr_pend   = 1'b0;
    x_pend_new   = fa;
    x_set_halt   = 1'b0;
    x_div        = 1'b0;
    x_res.request_kind = KIND_DONE;
    if (it.action == ACT_RESP) begin
      if (pend_valid) begin
        x_wb_en    = 1'b1;
        x_wb_addr  = pend_reg;
        x_wb_data  = it.response_value;
        x_clr_pend = 1'b1;
      end
    end else if (halted) begin
      x_res.request_kind = KIND_HALT;
    end else if (pend_valid) begin
      x_res.request_kind = KIND_FAULT;
    end else begin
      case (op)
        OP_CMOV: begin
          x_wb_en   = (rc != '0);
          x_wb_data = rb;
        end
        OP_LOAD: begin
          x_res.request_kind = KIND_LOAD;
          x_res.segment_id   = rb;
          x_res.word_offset  = rc;
          x_set_pend         = 1'b1;
        end
        OP_STORE: begin
          x_res.request_kind = KIND_STORE;
          x_res.segment_id   = ra;
          x_res.word_offset  = rb;
          x_res.data_value   = rc;
        end
        OP_ADD: begin
          x_wb_en   = 1'b1;
          x_wb_data = rb + rc;
        end
        OP_MUL: begin
          x_wb_en   = 1'b1;
          x_wb_data = WORD_W'(rb * rc);
        end
        OP_DIV: begin
          if (rc == '0) begin
            x_res.request_kind = KIND_FAULT;
          end else begin
            x_wb_en = 1'b1;
            x_div   = 1'b1;
          end
        end
        OP_NAND: begin
          x_wb_en   = 1'b1;
          x_wb_data = ~(rb & rc);
        end
        OP_HALT: begin
          x_res.request_kind = KIND_HALT;
          x_set_halt         = 1'b1;
        end
        OP_MAP: begin
          x_res.request_kind = KIND_MAP;
          x_res.data_value   = rc;
          x_set_pend         = 1'b1;
          x_pend_new         = fb;
        end
        OP_UNMAP: begin
          x_res.request_kind = KIND_UNMAP;
          x_res.segment_id   = rc;
        end
        OP_OUT: begin
          x_res.request_kind = KIND_OUTPUT;
          x_res.data_value   = {{(WORD_W-CHAR_W){1'b0}}, rc[CHAR_W-1:0]};
        end
        OP_IN: begin
          x_wb_en   = 1'b1;
          x_wb_addr = fc;
          x_wb_data = it.input_end ? '1 : {{(WORD_W-CHAR_W){1'b0}}, it.input_char};
        end
        OP_LDPRG: begin
          x_npc = rc;
          if (rb != '0) begin
            x_res.request_kind = KIND_LOADPROG;
            x_res.segment_id   = rb;
            x_res.data_value   = rc;
          end
        end
        OP_LDVAL: begin
          x_wb_en   = 1'b1;
          x_wb_addr = it.instruction[LV_W+REG_AW-1:LV_W];
          x_wb_data = {{(WORD_W-LV_W){1'b0}}, it.instruction[LV_W-1:0]};
        end
        default: begin
          x_res.request_kind = KIND_FAULT;
        end
      endcase
      x_pc_upd = (x_res.request_kind != KIND_FAULT) && (x_res.request_kind != KIND_HALT);
    end
    x_res.next_pc = x_pc_upd ? x_npc : pc;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_RDA;
      ST_RDA:  state_next = ST_EXEC;
      ST_EXEC: state_next = x_div ? ST_DIV : ST_FIN;
      ST_DIV:  if (!div_busy) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      pend_reg   <= '0;
      pend_valid <= 1'b0;
      halted     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // output valid: set on commit, cleared when the item leaves
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        if (pc_upd) begin
          pc <= pc_new;
        end
        if (set_pend) begin
          pend_valid <= 1'b1;
          pend_reg   <= pend_new;
        end else if (clr_pend) begin
          pend_valid <= 1'b0;
        end
        if (set_halt) begin
          halted <= 1'b1;
        end
      end
    end
  end

  // item, operand and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it <= in_item;
    end
    if (state == ST_RDA) begin
      rb <= rd0_data;
      rc <= rd1_data;
    end
    if (state == ST_EXEC) begin
      res      <= x_res;
      wb_en    <= x_wb_en;
      wb_addr  <= x_wb_addr;
      wb_data  <= x_wb_data;
      pc_upd   <= x_pc_upd;
      pc_new   <= x_npc;
      set_pend <= x_set_pend;
      clr_pend <= x_clr_pend;
      pend_new <= x_pend_new;
      set_halt <= x_set_halt;
    end
    if ((state == ST_DIV) && !div_busy) begin
      wb_data <= div_quo;
    end
    if (commit) begin
      out_item <= res;
    end
  end

endmodule

[design/umec_regfile.sv]
// register file memory: two registered read ports, one write port, reset by valid bits
module umec_regfile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [umec_pkg::REG_AW-1:0]  rd0_addr,
  input  logic [umec_pkg::REG_AW-1:0]  rd1_addr,
  output logic [umec_pkg::WORD_W-1:0]  rd0_data,
  output logic [umec_pkg::WORD_W-1:0]  rd1_data,
  input  logic                         wr_en,
  input  logic [umec_pkg::REG_AW-1:0]  wr_addr,
  input  logic [umec_pkg::WORD_W-1:0]  wr_data
);
  import umec_pkg::*;

  logic [WORD_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [WORD_W-1:0]    q0;
  logic [WORD_W-1:0]    q1;
  logic                 v0;
  logic                 v1;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q0 <= mem[rd0_addr];
    q1 <= mem[rd1_addr];
  end

  // entry written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v0  <= 1'b0;
      v1  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      v0 <= vld[rd0_addr];
      v1 <= vld[rd1_addr];
    end
  end

  // unwritten entries read as zero
  assign rd0_data = v0 ? q0 : '0;
  assign rd1_data = v1 ? q1 : '0;

endmodule

[design/umec_divider.sv]
// restoring unsigned divider, one quotient bit per cycle
module umec_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [umec_pkg::WORD_W-1:0] dividend,
  input  logic [umec_pkg::WORD_W-1:0] divisor,
  output logic                        busy,
  output logic [umec_pkg::WORD_W-1:0] quotient
);
  import umec_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // one trial subtraction
  assign shifted = {rem, quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(WORD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

[tb/umec_result_checker.sv]
// result checker for the execute core: predicts each result and compares it
`timescale 1ns / 100ps

module umec_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  umec_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  umec_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  outstanding
);
  import umec_pkg::*;

  // predicted machine state
  logic [WORD_W-1:0] regs [REG_COUNT];
  logic [WORD_W-1:0] pc;
  logic [REG_AW-1:0] dest_idx;
  logic              dest_busy;
  logic              halt_seen;

  out_item_t awaited_results[$];

  // one item through the machine: update state, return the expected result
  function automatic out_item_t compute_result(in_item_t it);
    out_item_t         res;
    logic [OP_W-1:0]   op;
    logic [REG_AW-1:0] ra;
    logic [REG_AW-1:0] rb;
    logic [REG_AW-1:0] rc;
    logic [WORD_W-1:0] npc;
    op  = it.instruction[31:28];
    ra  = it.instruction[8:6];
    rb  = it.instruction[5:3];
    rc  = it.instruction[2:0];
    res = '0;
    res.request_kind = KIND_DONE;
    npc = pc + 32'd1;
    if (it.action == ACT_RESP) begin
      // returned word or segment id lands in the marked register
      if (dest_busy) begin
        regs[dest_idx] = it.response_value;
        dest_busy = 1'b0;
      end
    end else if (halt_seen) begin
      res.request_kind = KIND_HALT;
    end else if (dest_busy) begin
      res.request_kind = KIND_FAULT;
    end else begin
      case (op)
        OP_CMOV: begin
          if (regs[rc] != '0) regs[ra] = regs[rb];
        end
        OP_LOAD: begin
          res.request_kind = KIND_LOAD;
          res.segment_id   = regs[rb];
          res.word_offset  = regs[rc];
          dest_idx  = ra;
          dest_busy = 1'b1;
        end
        OP_STORE: begin
          res.request_kind = KIND_STORE;
          res.segment_id   = regs[ra];
          res.word_offset  = regs[rb];
          res.data_value   = regs[rc];
        end
        OP_ADD: regs[ra] = regs[rb] + regs[rc];
        OP_MUL: regs[ra] = regs[rb] * regs[rc];
        OP_DIV: begin
          if (regs[rc] == '0) res.request_kind = KIND_FAULT;
          else regs[ra] = regs[rb] / regs[rc];
        end
        OP_NAND: regs[ra] = ~(regs[rb] & regs[rc]);
        OP_HALT: begin
          res.request_kind = KIND_HALT;
          halt_seen = 1'b1;
        end
        OP_MAP: begin
          res.request_kind = KIND_MAP;
          res.data_value   = regs[rc];
          dest_idx  = rb;
          dest_busy = 1'b1;
        end
        OP_UNMAP: begin
          res.request_kind = KIND_UNMAP;
          res.segment_id   = regs[rc];
        end
        OP_OUT: begin
          res.request_kind = KIND_OUTPUT;
          res.data_value   = {24'd0, regs[rc][7:0]};
        end
        OP_IN: regs[rc] = it.input_end ? '1 : {24'd0, it.input_char};
        OP_LDPRG: begin
          // jump always taken; segment zero needs no request
          npc = regs[rc];
          if (regs[rb] != '0) begin
            res.request_kind = KIND_LOADPROG;
            res.segment_id   = regs[rb];
            res.data_value   = regs[rc];
          end
        end
        OP_LDVAL: regs[it.instruction[27:25]] = {7'd0, it.instruction[LV_W-1:0]};
        default: res.request_kind = KIND_FAULT;
      endcase
      if (res.request_kind != KIND_FAULT && res.request_kind != KIND_HALT) pc = npc;
    end
    res.next_pc = pc;
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
      pc         = '0;
      dest_idx   = '0;
      dest_busy  = 1'b0;
      halt_seen  = 1'b0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind=%0d seg=%0h off=%0h data=%0h pc=%0h",
                     $time, out_item.request_kind, out_item.segment_id,
                     out_item.word_offset, out_item.data_value, out_item.next_pc);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.request_kind !== want.request_kind ||
              out_item.segment_id   !== want.segment_id   ||
              out_item.word_offset  !== want.word_offset  ||
              out_item.data_value   !== want.data_value   ||
              out_item.next_pc      !== want.next_pc) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch expected kind=%0d seg=%0h off=%0h data=%0h pc=%0h",
                       $time, want.request_kind, want.segment_id, want.word_offset,
                       want.data_value, want.next_pc);
              $display("%0t:          actual   kind=%0d seg=%0h off=%0h data=%0h pc=%0h",
                       $time, out_item.request_kind, out_item.segment_id,
                       out_item.word_offset, out_item.data_value, out_item.next_pc);
            end
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(compute_result(in_item));
    end
    outstanding = awaited_results.size();
  end

endmodule

[tb/tb_universal_machine_execute_core.sv]
// testbench top for the execute core: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_universal_machine_execute_core;
  import umec_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 1500000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        fail_count;
  int        outstanding;
  int        cycle_cnt;
  int        quiet_in;

  universal_machine_execute_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  umec_result_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // register-format instruction; unused bits carry noise
  function automatic logic [WORD_W-1:0] mk_abc(logic [OP_W-1:0] op, int a, int b, int c);
    logic [18:0] filler;
    filler = 19'($urandom);
    return {op, filler, a[2:0], b[2:0], c[2:0]};
  endfunction

  function automatic logic [WORD_W-1:0] mk_ldval(int a, logic [LV_W-1:0] val);
    return {OP_LDVAL, a[2:0], val};
  endfunction

  function automatic in_item_t exec_item(logic [WORD_W-1:0] word, logic [7:0] ch, logic eof);
    in_item_t it;
    it.action         = ACT_EXEC;
    it.instruction    = word;
    it.input_char     = ch;
    it.input_end      = eof;
    it.response_value = $urandom;
    return it;
  endfunction

  function automatic in_item_t resp_item(logic [WORD_W-1:0] val);
    in_item_t it;
    it.action         = ACT_RESP;
    it.instruction    = $urandom;
    it.input_char     = 8'($urandom);
    it.input_end      = 1'($urandom);
    it.response_value = val;
    return it;
  endfunction

  // response words lean toward extremes and small ids
  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return $urandom_range(1, 15);
    return $urandom;
  endfunction

  // random instruction of any kind but halt
  function automatic logic [WORD_W-1:0] rand_instr();
    int r;
    int v;
    logic [LV_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      v = $urandom_range(0, 9);
      if (v < 3) val = '0;
      else if (v == 3) val = '1;
      else if (v < 6) val = LV_W'($urandom_range(1, 15));
      else val = LV_W'($urandom);
      return mk_ldval($urandom_range(0, 7), val);
    end
    if (r < 22) return mk_abc(OP_ADD, $urandom, $urandom, $urandom);
    if (r < 28) return mk_abc(OP_MUL, $urandom, $urandom, $urandom);
    if (r < 36) return mk_abc(OP_DIV, $urandom, $urandom, $urandom);
    if (r < 42) return mk_abc(OP_NAND, $urandom, $urandom, $urandom);
    if (r < 48) return mk_abc(OP_CMOV, $urandom, $urandom, $urandom);
    if (r < 56) return mk_abc(OP_LOAD, $urandom, $urandom, $urandom);
    if (r < 62) return mk_abc(OP_STORE, $urandom, $urandom, $urandom);
    if (r < 70) return mk_abc(OP_MAP, $urandom, $urandom, $urandom);
    if (r < 74) return mk_abc(OP_UNMAP, $urandom, $urandom, $urandom);
    if (r < 80) return mk_abc(OP_OUT, $urandom, $urandom, $urandom);
    if (r < 88) return mk_abc(OP_IN, $urandom, $urandom, $urandom);
    if (r < 95) return mk_abc(OP_LDPRG, $urandom, $urandom, $urandom);
    // undefined opcodes 14 and 15
    return {2'b11, 1'b1, 1'($urandom), 28'($urandom)};
  endfunction

  // present one item after a random gap and hold it until taken
  task automatic drive(in_item_t it);
    int gap;
    int r;
    if (quiet_in > 0) begin
      quiet_in--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 199);
      if (r == 0) begin
        quiet_in = $urandom_range(30, 100);
        gap = 0;
      end else if (r < 110) gap = 0;
      else if (r < 170) gap = $urandom_range(1, 3);
      else if (r < 194) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // receiver stalls: mostly short, a few long, with calm stretches
  initial begin
    int hold;
    int calm;
    int r;
    out_ready = 1'b0;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
        end else if (r < 63) begin
          calm = $urandom_range(30, 120);
          out_ready <= 1'b1;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) hold = $urandom_range(0, 2);
          else if (r < 95) hold = $urandom_range(3, 10);
          else hold = $urandom_range(20, 60);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int n_done;
    int r;
    int wait_cnt;
    logic busy_dest;
    logic [WORD_W-1:0] w;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_item  = '0;
    quiet_in = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every opcode but halt, special cases
    drive(exec_item(mk_abc(OP_CMOV, 1, 2, 0), 8'h00, 1'b0));   // condition zero, no move
    drive(exec_item(mk_ldval(1, '1), 8'h00, 1'b0));
    drive(exec_item(mk_ldval(3, 25'd7), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_IN, 0, 0, 4), 8'h5a, 1'b1));     // end of input, all ones
    drive(exec_item(mk_abc(OP_IN, 0, 0, 5), 8'hff, 1'b0));
    drive(exec_item(mk_abc(OP_ADD, 6, 4, 1), 8'h00, 1'b0));    // wraps
    drive(exec_item(mk_abc(OP_MUL, 7, 4, 4), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_DIV, 0, 4, 3), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_DIV, 6, 4, 2), 8'h00, 1'b0));    // divide by zero
    drive(exec_item(mk_abc(OP_NAND, 6, 4, 4), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_CMOV, 6, 1, 3), 8'h00, 1'b0));   // condition set
    drive(exec_item(mk_abc(OP_OUT, 0, 0, 4), 8'h00, 1'b0));    // only low byte leaves
    drive(exec_item(mk_abc(OP_STORE, 1, 3, 4), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_UNMAP, 0, 0, 4), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_LOAD, 5, 1, 3), 8'h00, 1'b0));
    drive(exec_item(mk_abc(OP_ADD, 2, 1, 1), 8'h00, 1'b0));    // faults while waiting
    drive(resp_item('1));
    drive(resp_item(32'h1234_5678));                           // nothing waiting
    drive(exec_item(mk_abc(OP_MAP, 0, 0, 3), 8'h00, 1'b0));
    drive(resp_item('0));
    drive(exec_item(mk_abc(OP_LDPRG, 0, 2, 4), 8'h00, 1'b0));  // segment zero, pc to all ones
    drive(exec_item(mk_ldval(7, '0), 8'h00, 1'b0));            // pc wraps
    drive(exec_item(mk_abc(OP_LDPRG, 0, 1, 3), 8'h00, 1'b0));
    drive(exec_item({4'd14, 28'($urandom)}, 8'h00, 1'b0));
    drive(exec_item({4'd15, 28'($urandom)}, 8'h00, 1'b0));

    // random: mostly request/response pairs kept well formed, some noise
    n_done = 0;
    busy_dest = 1'b0;
    while (n_done < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (busy_dest) begin
        if (r < 88) begin
          drive(resp_item(pick_word()));
          busy_dest = 1'b0;
          n_done++;
        end else begin
          drive(exec_item(rand_instr(), 8'($urandom), $urandom_range(0, 4) == 0));
        end
      end else if (r < 3) begin
        drive(resp_item(pick_word()));
      end else begin
        w = rand_instr();
        drive(exec_item(w, 8'($urandom), $urandom_range(0, 4) == 0));
        n_done++;
        if (w[31:28] == OP_LOAD || w[31:28] == OP_MAP) busy_dest = 1'b1;
      end
    end

    // halt, then the machine stays halted
    if (busy_dest) drive(resp_item(pick_word()));
    drive(exec_item(mk_abc(OP_HALT, $urandom, $urandom, $urandom), 8'($urandom), 1'b0));
    repeat (3) drive(exec_item(rand_instr(), 8'($urandom), 1'($urandom)));
    drive(resp_item(pick_word()));
    in_valid <= 1'b0;

    // drain
    wait_cnt = 0;
    while (outstanding != 0 && wait_cnt < 20000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (60) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
